/* src/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, slot counts and slot decode helpers for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	// Command codes as carried on the input beat
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	localparam int unsigned SLOT_W = 5;

	// Slot counts per command
	localparam logic [SLOT_W-1:0] CTRL_SLOTS  = 5'd3;
	localparam logic [SLOT_W-1:0] WRITE_SLOTS = 5'd27;
	localparam logic [SLOT_W-1:0] READ_SLOTS  = 5'd19;

	// Named slots inside the write and read lists
	localparam logic [SLOT_W-1:0] WR_DATA_END    = 5'd24;
	localparam logic [SLOT_W-1:0] WR_ACK_RELEASE = 5'd24;
	localparam logic [SLOT_W-1:0] WR_ACK_HIGH    = 5'd25;
	localparam logic [SLOT_W-1:0] RD_ACK_SLOT    = 5'd16;
	localparam logic [SLOT_W-1:0] RD_LAST_SLOT   = 5'd18;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd32;

	// One input beat
	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] tx_byte;
		logic       rd_ack;
		logic       sda_in;
	} item_t;

	// One result beat, scl_release in the lowest bit
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       ack_ok;
		logic       done_res;
		logic       busy_res;
		logic       sda_release;
		logic       scl_release;
	} res_t;

	// Sequencer state apart from the divider
	typedef struct packed {
		op_t               cmd;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        shift;
		logic              ack_choice;
		logic              scl;
		logic              sda;
		logic              ack_seen;
	} ctl_t;

	// Phase and bit position of a write data slot
	typedef struct packed {
		logic [1:0] phase;
		logic [2:0] pos;
	} wr_info_t;

	function automatic logic [SLOT_W-1:0] slot_total(op_t cmd);
		logic [SLOT_W-1:0] n;
		n = CTRL_SLOTS;
		if (cmd == OP_WRITE) n = WRITE_SLOTS;
		if (cmd == OP_READ) n = READ_SLOTS;
		return n;
	endfunction

	// Map a write data slot (below 24) to its phase and bit position
	function automatic wr_info_t write_slot_info(logic [SLOT_W-1:0] s);
		wr_info_t info;
		info = '0;
		for (int b = 0; b < 8; b++) begin
			if (s >= SLOT_W'(3 * b) && s < SLOT_W'(3 * b + 3)) begin
				info.phase = 2'(s - SLOT_W'(3 * b));
				info.pos   = 3'(7 - b);
			end
		end
		return info;
	endfunction

endpackage

/* src/i2cm_step.sv */
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state and result logic of the slot sequencer for one bus tick.
// ----------------------------------------------------------------------------
module i2cm_step #(
	parameter int DIVIDER_WIDTH = 16
) (
	input  i2cm_pkg::ctl_t             cur,
	input  logic [DIVIDER_WIDTH-1:0]   div_cur,
	input  logic [DIVIDER_WIDTH-1:0]   limit,
	input  i2cm_pkg::item_t            item,
	output i2cm_pkg::ctl_t             nxt,
	output logic [DIVIDER_WIDTH-1:0]   div_nxt,
	output i2cm_pkg::res_t             res
);
	import i2cm_pkg::*;

	logic                     done;
	logic                     run;
	logic                     op_ok;
	logic [DIVIDER_WIDTH-1:0] div_inc;
	logic [SLOT_W-1:0]        slot_inc;
	wr_info_t                 wr_info;

	assign op_ok = (item.operation == OP_START) || (item.operation == OP_STOP) ||
		(item.operation == OP_WRITE) || (item.operation == OP_READ);
	assign div_inc  = div_cur + DIVIDER_WIDTH'(1);
	assign slot_inc = cur.slot + SLOT_W'(1);

	// Next state: take a command, advance the divider, run the slot
	always_comb begin
		nxt     = cur;
		div_nxt = div_cur;
		done    = 1'b0;
		run     = 1'b0;
		wr_info = '0;
		if (cur.cmd == OP_NONE) begin
			if (op_ok) begin
				nxt.cmd      = op_t'(item.operation);
				nxt.slot     = '0;
				div_nxt      = '0;
				nxt.ack_seen = 1'b0;
				if (item.operation == OP_WRITE) nxt.shift = item.tx_byte;
				if (item.operation == OP_READ) begin
					nxt.shift      = '0;
					nxt.ack_choice = item.rd_ack;
				end
				run = 1'b1;
			end
		end else if (div_inc >= limit || div_inc == '0) begin
			div_nxt = '0;
			if (slot_inc >= slot_total(cur.cmd)) begin
				done     = 1'b1;
				nxt.cmd  = OP_NONE;
				nxt.slot = '0;
				if (cur.cmd == OP_READ) nxt.sda = 1'b1;
			end else begin
				nxt.slot = slot_inc;
				run      = 1'b1;
			end
		end else begin
			div_nxt = div_inc;
		end

		// Apply the line changes of the slot that starts on this tick
		if (run) begin
			unique case (nxt.cmd)
				OP_START: begin
					if (nxt.slot == 5'd0) begin
						nxt.sda = 1'b1;
						nxt.scl = 1'b1;
					end else if (nxt.slot == 5'd1) begin
						nxt.sda = 1'b0;
					end else begin
						nxt.scl = 1'b0;
					end
				end
				OP_STOP: begin
					if (nxt.slot == 5'd0) nxt.sda = 1'b0;
					else if (nxt.slot == 5'd1) nxt.scl = 1'b1;
					else nxt.sda = 1'b1;
				end
				OP_WRITE: begin
					wr_info = write_slot_info(nxt.slot);
					if (nxt.slot < WR_DATA_END) begin
						if (wr_info.phase == 2'd0) nxt.sda = nxt.shift[wr_info.pos];
						else if (wr_info.phase == 2'd1) nxt.scl = 1'b1;
						else nxt.scl = 1'b0;
					end else if (nxt.slot == WR_ACK_RELEASE) begin
						nxt.sda = 1'b1;
					end else if (nxt.slot == WR_ACK_HIGH) begin
						nxt.scl = 1'b1;
					end else begin
						nxt.ack_seen = ~item.sda_in;
						nxt.scl      = 1'b0;
					end
				end
				OP_READ: begin
					if (nxt.slot == 5'd0) begin
						nxt.sda = 1'b1;
					end else if (nxt.slot == RD_LAST_SLOT) begin
						nxt.scl = 1'b0;
					end else if (nxt.slot[0]) begin
						nxt.scl = 1'b1;
					end else begin
						nxt.shift = {nxt.shift[6:0], item.sda_in};
						nxt.scl   = 1'b0;
						if (nxt.slot == RD_ACK_SLOT) nxt.sda = ~nxt.ack_choice;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result beat: line drives after the tick, done pulse with ack and byte
	always_comb begin
		res             = '0;
		res.scl_release = nxt.scl;
		res.sda_release = nxt.sda;
		res.busy_res    = (nxt.cmd != OP_NONE);
		res.done_res    = done;
		res.ack_ok      = done && (cur.cmd == OP_WRITE) && cur.ack_seen;
		res.rx_byte     = (done && (cur.cmd == OP_READ)) ? cur.shift : 8'd0;
	end

endmodule

/* src/i2c_master_byte_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master bit sequencer driven one beat per bus tick.
// ----------------------------------------------------------------------------
// Each input beat is one tick of bus timing and carries an optional command
// (start, stop, write byte, read byte) plus the sampled SDA level; each beat
// yields exactly one result beat with the open-drain SCL/SDA drives, busy,
// a done pulse, the write ack and the read byte. The engine takes one beat
// per clock cycle while the output is not stalled; a beat is captured in the
// input register, and its result beat moves on to the result register and
// is offered on the output from there. A stalled output holds the result
// register, then the input register, and after that the input stalls too.
// Bus timing is set by half_period_ticks (ticks per half-bit slot, zero
// counts as one); commands arriving while busy are ignored.
module i2c_master_byte_engine #(
	parameter int DIVIDER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: half_period_ticks
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// input beats
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] tx_byte, [8] rd_ack, [9] sda_in
	input  logic [2:0]  s_axis_tuser,  // [2:0] operation
	// result beats
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
	// [4] ack_ok, [12:5] rx_byte
	output logic [15:0] m_axis_tdata
);
	import i2cm_pkg::*;

	localparam int LIMIT_W = (DIVIDER_WIDTH > 16) ? DIVIDER_WIDTH : 16;

	logic [15:0]              half_period_q;
	item_t                    item_s1;
	logic                     valid_s1;
	ctl_t                     ctl_q;
	logic [DIVIDER_WIDTH-1:0] div_q;
	res_t                     res_s2;
	logic                     valid_s2;

	ctl_t                     ctl_nxt;
	logic [DIVIDER_WIDTH-1:0] div_nxt;
	res_t                     res_nxt;
	logic                     advance;
	logic [15:0]              half_eff;
	logic [LIMIT_W-1:0]       half_ext;
	logic [LIMIT_W-1:0]       div_max_ext;
	logic [LIMIT_W-1:0]       limit_ext;
	logic [DIVIDER_WIDTH-1:0] limit;

	// Slot length: zero counts as one, clamp to the divider range
	assign half_eff    = (half_period_q == 16'd0) ? 16'd1 : half_period_q;
	assign half_ext    = LIMIT_W'(half_eff);
	assign div_max_ext = LIMIT_W'({DIVIDER_WIDTH{1'b1}});
	assign limit_ext   = (half_ext > div_max_ext) ? div_max_ext : half_ext;
	assign limit       = limit_ext[DIVIDER_WIDTH-1:0];

	// Move a beat into the result register when it is free or being taken
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_wr_en) begin
			half_period_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= '{operation: s_axis_tuser, tx_byte: s_axis_tdata[7:0],
				rd_ack: s_axis_tdata[8], sda_in: s_axis_tdata[9]};
		end
	end

	i2cm_step #(
		.DIVIDER_WIDTH(DIVIDER_WIDTH)
	) u_step (
		.cur    (ctl_q),
		.div_cur(div_q),
		.limit  (limit),
		.item   (item_s1),
		.nxt    (ctl_nxt),
		.div_nxt(div_nxt),
		.res    (res_nxt)
	);

	// Advance sequencer state once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '{cmd: OP_NONE, slot: '0, shift: '0, ack_choice: 1'b0,
				scl: 1'b1, sda: 1'b1, ack_seen: 1'b0};
			div_q <= '0;
		end else if (advance) begin
			ctl_q <= ctl_nxt;
			div_q <= div_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, res_s2};

endmodule

/* src/i2cm_checker.sv */
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// A finished command leaves the engine idle in the same beat
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
		else $error("done beat still shows busy");

	// Ack is only reported on a done beat
	a_ack_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3])
		else $error("ack_ok outside a done beat");

	// Read byte is zero except on a done beat
	a_rx_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[12:5] != 8'd0) |-> m_axis_tdata[3])
		else $error("rx_byte outside a done beat");

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

/* test/tb_i2c_master_byte_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine
// Self-checking stream testbench for the I2C master byte engine.
// ----------------------------------------------------------------------------
// Bus ticks are built in an initial block. Each tick is run through a local
// model of the slot sequencer as it is queued, and the line state it gives is
// kept in order. A clocked driver offers the ticks with random gaps. A clocked
// monitor checks every result beat against the oldest line state due. The run
// covers start, stop, write and read with forced and random SDA levels,
// commands while busy and on the finishing tick, and unused operation codes.
// It steps the half period through the reset value, zero, one, small values
// and the largest value.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine;
	import i2cm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned LONG_HOLD   = 300;

	// Operation codes the engine has no use for
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

	typedef enum {SDA_LOW, SDA_ONE, SDA_RAND} sda_mode_e;
	typedef enum {BUSY_QUIET, BUSY_NOISE, BUSY_CMDS} busy_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [7:0] tx_byte, [8] rd_ack, [9] sda_in
	logic [2:0]  s_axis_tuser = '0;  // [2:0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
	// [4] ack_ok, [12:5] rx_byte
	logic [15:0] m_axis_tdata;

	// Ticks waiting for the driver, line states waiting for the monitor
	item_t ticks_to_send[$];
	res_t  line_states_due[$];

	// Sequencer copy, advanced as ticks are queued
	op_t               seq_cmd = OP_NONE;
	logic [SLOT_W-1:0] seq_slot = '0;
	logic [15:0]       seq_div = '0;
	logic [7:0]        seq_shift = '0;
	logic              seq_ack_choice = 1'b0;
	logic              seq_scl = 1'b1;
	logic              seq_sda = 1'b1;
	logic              seq_ack_seen = 1'b0;
	logic [15:0]       seq_period = HALF_PERIOD_RESET;

	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned commands_issued = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_served = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	int unsigned gap_left = 0;
	bit          calm = 1'b0;
	bit          item_taken = 1'b0;

	i2c_master_byte_engine #(
		.DIVIDER_WIDTH(16)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm) return 0;
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic pick_sda(sda_mode_e m);
		case (m)
			SDA_LOW:  return 1'b0;
			SDA_ONE:  return 1'b1;
			default:  return 1'($urandom);
		endcase
	endfunction

	// Apply the line changes of the current slot
	task automatic play_slot(input logic sda_now);
		int s;
		int ph;
		int pos;
		s = int'(seq_slot);
		case (seq_cmd)
			OP_START: begin
				if (s == 0) begin
					seq_sda = 1'b1;
					seq_scl = 1'b1;
				end else if (s == 1) seq_sda = 1'b0;
				else seq_scl = 1'b0;
			end
			OP_STOP: begin
				if (s == 0) seq_sda = 1'b0;
				else if (s == 1) seq_scl = 1'b1;
				else seq_sda = 1'b1;
			end
			OP_WRITE: begin
				if (seq_slot < WR_DATA_END) begin
					ph  = s % 3;
					pos = 7 - s / 3;
					if (ph == 0) seq_sda = seq_shift[pos];
					else if (ph == 1) seq_scl = 1'b1;
					else seq_scl = 1'b0;
				end else if (seq_slot == WR_ACK_RELEASE) begin
					seq_sda = 1'b1;
				end else if (seq_slot == WR_ACK_HIGH) begin
					seq_scl = 1'b1;
				end else begin
					seq_ack_seen = ~sda_now;
					seq_scl = 1'b0;
				end
			end
			OP_READ: begin
				if (s == 0) begin
					seq_sda = 1'b1;
				end else if (seq_slot == RD_LAST_SLOT) begin
					seq_scl = 1'b0;
				end else if (seq_slot[0]) begin
					seq_scl = 1'b1;
				end else begin
					seq_shift = {seq_shift[6:0], sda_now};
					seq_scl = 1'b0;
					if (seq_slot == RD_ACK_SLOT) seq_sda = ~seq_ack_choice;
				end
			end
			default: ;
		endcase
	endtask

	// Advance the sequencer by one bus tick and give the line state after it
	task automatic sequence_tick(input item_t it, output res_t r);
		logic [15:0]       lim;
		logic [SLOT_W-1:0] slots;
		r = '0;
		if (seq_cmd == OP_NONE) begin
			if (it.operation >= OP_START && it.operation <= OP_READ) begin
				seq_cmd = op_t'(it.operation);
				seq_slot = '0;
				seq_div = '0;
				seq_ack_seen = 1'b0;
				if (seq_cmd == OP_WRITE) seq_shift = it.tx_byte;
				if (seq_cmd == OP_READ) begin
					seq_shift = '0;
					seq_ack_choice = it.rd_ack;
				end
				play_slot(it.sda_in);
			end
		end else begin
			lim = (seq_period == '0) ? 16'd1 : seq_period;
			seq_div = seq_div + 16'd1;
			if (seq_div >= lim || seq_div == '0) begin
				seq_div = '0;
				seq_slot = seq_slot + SLOT_W'(1);
				case (seq_cmd)
					OP_WRITE: slots = WRITE_SLOTS;
					OP_READ:  slots = READ_SLOTS;
					default:  slots = CTRL_SLOTS;
				endcase
				if (seq_slot >= slots) begin
					r.done_res = 1'b1;
					if (seq_cmd == OP_WRITE) r.ack_ok = seq_ack_seen;
					if (seq_cmd == OP_READ) begin
						r.rx_byte = seq_shift;
						seq_sda = 1'b1;
					end
					seq_cmd = OP_NONE;
					seq_slot = '0;
				end else begin
					play_slot(it.sda_in);
				end
			end
		end
		r.scl_release = seq_scl;
		r.sda_release = seq_sda;
		r.busy_res    = (seq_cmd != OP_NONE);
	endtask

	task automatic queue_tick(input item_t it);
		res_t r;
		sequence_tick(it, r);
		ticks_to_send.push_back(it);
		line_states_due.push_back(r);
	endtask

	// Issue one command and fill the ticks until the engine is idle again
	task automatic run_command(input logic [2:0] op, input logic [7:0] tx, input logic ack,
			input sda_mode_e sm, input busy_mode_e bm);
		item_t it;
		it.operation = op;
		it.tx_byte   = tx;
		it.rd_ack    = ack;
		it.sda_in    = pick_sda(sm);
		queue_tick(it);
		commands_issued++;
		while (seq_cmd != OP_NONE) begin
			it.tx_byte  = 8'($urandom);
			it.rd_ack   = 1'($urandom);
			it.sda_in   = pick_sda(sm);
			case (bm)
				BUSY_QUIET: it.operation = OP_NONE;
				BUSY_NOISE: it.operation = ($urandom_range(0, 3) == 0) ?
					3'($urandom_range(OP_START, OP_UNUSED_LAST)) : OP_NONE;
				default: it.operation = 3'($urandom_range(OP_START, OP_READ));
			endcase
			queue_tick(it);
		end
	endtask

	// Idle ticks, some carrying unused operation codes
	task automatic quiet_ticks(input int n);
		item_t it;
		for (int k = 0; k < n; k++) begin
			it.operation = ($urandom_range(0, 3) == 0) ?
				3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)) : OP_NONE;
			it.tx_byte  = 8'($urandom);
			it.rd_ack   = 1'($urandom);
			it.sda_in   = 1'($urandom);
			queue_tick(it);
		end
	endtask

	// A start whose slots outlast the run: only its first ticks are sent
	task automatic start_unfinished(input int n);
		item_t it;
		it.operation = OP_START;
		it.tx_byte   = 8'($urandom);
		it.rd_ack    = 1'($urandom);
		it.sda_in    = 1'($urandom);
		queue_tick(it);
		commands_issued++;
		quiet_ticks(n);
	endtask

	function automatic busy_mode_e pick_busy();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6) return BUSY_QUIET;
		if (r < 9) return BUSY_NOISE;
		return BUSY_CMDS;
	endfunction

	// Start, address, up to three data bytes, stop
	task automatic random_transfer();
		int  n;
		bit  rd;
		run_command(OP_START, 8'($urandom), 1'($urandom), SDA_RAND, pick_busy());
		quiet_ticks($urandom_range(0, 2));
		run_command(OP_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, pick_busy());
		n  = $urandom_range(0, 3);
		rd = 1'($urandom);
		for (int k = 0; k < n; k++) begin
			quiet_ticks($urandom_range(0, 2));
			if (rd) run_command(OP_READ, 8'($urandom), k != n - 1, SDA_RAND, pick_busy());
			else run_command(OP_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, pick_busy());
		end
		quiet_ticks($urandom_range(0, 2));
		run_command(OP_STOP, 8'($urandom), 1'($urandom), SDA_RAND, pick_busy());
		quiet_ticks($urandom_range(0, 4));
	endtask

	// Single commands of any nonzero code, out of protocol order
	task automatic random_noise();
		run_command(3'($urandom_range(OP_START, OP_UNUSED_LAST)), 8'($urandom), 1'($urandom),
			SDA_RAND, pick_busy());
		quiet_ticks($urandom_range(0, 3));
	endtask

	task automatic random_phase(input int unsigned count);
		int unsigned goal;
		goal = commands_issued + count;
		while (commands_issued < goal) begin
			if ($urandom_range(0, 99) < 80) random_transfer();
			else random_noise();
		end
	endtask

	task automatic wait_drained();
		while (ticks_to_send.size() != 0 || line_states_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_half_period(input logic [15:0] v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		seq_period = v;
	endtask

	// Offer queued ticks, one beat at a time
	always @(negedge clk) begin : drive_ticks
		item_t it;
		logic  v;
		if (arst_n) begin
			v = s_axis_tvalid;
			if (s_axis_tvalid && item_taken) begin
				v = 1'b0;
				gap_left = pick_gap();
			end
			if (!v) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (ticks_to_send.size() > 0) begin
					it = ticks_to_send.pop_front();
					s_axis_tdata <= {6'b0, it.sda_in, it.rd_ack, it.tx_byte};
					s_axis_tuser <= it.operation;
					v = 1'b1;
				end
			end
			s_axis_tvalid <= v;
		end
	end

	// Pace the result side: random stalls, plus a long hold when asked
	always @(negedge clk) begin : pace_results
		logic rdy;
		if (arst_n) begin
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				if (!calm && $urandom_range(0, 99) < 25) stall_left = pick_gap();
			end
			m_axis_tready <= rdy;
		end
	end

	// Note input beats taken and check result beats
	always @(posedge clk) begin : check_results
		res_t got;
		res_t want;
		item_taken = s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = res_t'(m_axis_tdata[12:0]);
			if (line_states_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat %04h", $time, m_axis_tdata);
			end else begin
				want = line_states_due.pop_front();
				if (got.scl_release !== want.scl_release || got.sda_release !== want.sda_release ||
						got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
						got.ack_ok !== want.ack_ok || got.rx_byte !== want.rx_byte) begin
					mismatches++;
					$display("%0t: expected scl=%b sda=%b busy=%b done=%b ack=%b rx=%02h", $time,
						want.scl_release, want.sda_release, want.busy_res, want.done_res,
						want.ack_ok, want.rx_byte);
					$display("%0t: actual   scl=%b sda=%b busy=%b done=%b ack=%b rx=%02h", $time,
						got.scl_release, got.sda_release, got.busy_res, got.done_res,
						got.ack_ok, got.rx_byte);
				end
			end
		end
	end

	// Drop the run if it goes past the cycle limit
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("i2c_master_byte_engine: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset half period: plain start and stop
		run_command(OP_START, 8'h00, 1'b0, SDA_RAND, BUSY_QUIET);
		run_command(OP_STOP, 8'hFF, 1'b1, SDA_RAND, BUSY_QUIET);
		wait_drained();

		// Fastest pace: data extremes, forced ack and nack, both read ack choices
		set_half_period(16'd1);
		run_command(OP_START, 8'h00, 1'b0, SDA_RAND, BUSY_QUIET);
		run_command(OP_WRITE, 8'h00, 1'b0, SDA_LOW, BUSY_QUIET);
		run_command(OP_WRITE, 8'hFF, 1'b1, SDA_ONE, BUSY_QUIET);
		run_command(OP_READ, 8'h00, 1'b1, SDA_ONE, BUSY_QUIET);
		run_command(OP_READ, 8'hFF, 1'b0, SDA_LOW, BUSY_QUIET);
		// Commands on every busy tick, the finishing tick included
		run_command(OP_WRITE, 8'h5A, 1'b0, SDA_RAND, BUSY_CMDS);
		run_command(OP_READ, 8'hA5, 1'b1, SDA_RAND, BUSY_CMDS);
		run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND, BUSY_CMDS);
		// Unused codes while idle
		for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++)
			run_command(3'(c), 8'($urandom), 1'($urandom), SDA_RAND, BUSY_QUIET);
		run_command(OP_NONE, 8'hFF, 1'b1, SDA_ONE, BUSY_QUIET);
		wait_drained();

		// Zero half period counts as one
		set_half_period(16'd0);
		run_command(OP_START, 8'h00, 1'b0, SDA_RAND, BUSY_QUIET);
		run_command(OP_WRITE, 8'($urandom), 1'b0, SDA_RAND, BUSY_NOISE);
		run_command(OP_READ, 8'h00, 1'b0, SDA_RAND, BUSY_NOISE);
		run_command(OP_STOP, 8'h00, 1'b0, SDA_RAND, BUSY_QUIET);
		wait_drained();

		// Random transfers at one tick per slot, with a long hold on the result side
		set_half_period(16'd1);
		random_phase(12);
		calm = 1'b1;
		hold_requests++;
		while (holds_served != hold_requests || hold_left != 0) @(posedge clk);
		calm = 1'b0;
		wait_drained();

		set_half_period(16'd2);
		random_phase(4);
		wait_drained();

		set_half_period(16'd3);
		random_phase(4);
		wait_drained();

		set_half_period(16'($urandom_range(1, 4)));
		random_phase(4);
		wait_drained();

		set_half_period(16'($urandom_range(7, 24)));
		run_command(OP_START, 8'($urandom), 1'($urandom), SDA_RAND, BUSY_NOISE);
		run_command(OP_STOP, 8'($urandom), 1'($urandom), SDA_RAND, BUSY_NOISE);
		wait_drained();

		set_half_period(16'd0);
		random_phase(4);
		wait_drained();

		// Largest half period: the first ticks of a start, no idling
		calm = 1'b1;
		set_half_period(16'hFFFF);
		start_unfinished(40);
		wait_drained();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && line_states_due.size() == 0)
			$display("i2c_master_byte_engine: match");
		else
			$display("i2c_master_byte_engine: mismatch");
		$finish;
	end

endmodule
